// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker of the selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/rwbs_pkg.sv -----
// Package with codes, widths and the table entry type of the backend selector.
`timescale 1ns / 1ps
`default_nettype none

package rwbs_pkg;

  localparam int REQ_W  = 3;
  localparam int ID_W   = 5;
  localparam int KIND_W = 3;
  localparam int LAG_W  = 32;
  localparam int ACT_W  = 16;
  localparam int ST_W   = 2;

  localparam int MAX_BACKENDS_DEFAULT = 16;

  localparam logic [LAG_W-1:0] LAG_LIMIT_RESET = 32'd5000;
  localparam logic [ACT_W-1:0] ACT_MAX         = 16'hFFFF;

  localparam logic [REQ_W-1:0] REQ_ADD     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_UPDATE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SELECT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd4;

  localparam logic [KIND_W-1:0] KIND_READ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TXN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SESS  = 3'd3;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE    = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd3;

  localparam logic ROLE_PRIMARY = 1'b0;
  localparam logic ROLE_REPLICA = 1'b1;

  typedef struct packed {
    logic             role;
    logic             healthy;
    logic [LAG_W-1:0] lag;
    logic [ACT_W-1:0] active;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/rwbs_ifs.sv -----
// Channel interfaces of the selector: request, result and configuration write.
`timescale 1ns / 1ps
`default_nettype none

interface rwbs_req_if;
  logic                        valid;
  logic                        ready;
  logic [rwbs_pkg::REQ_W-1:0]  req_type;
  logic [rwbs_pkg::ID_W-1:0]   tgt_id;
  logic                        role;
  logic [rwbs_pkg::KIND_W-1:0] query_kind;
  logic                        healthy;
  logic [rwbs_pkg::LAG_W-1:0]  lag_ms;

  modport source (output valid, req_type, tgt_id, role, query_kind, healthy, lag_ms,
                  input ready);
  modport sink (input valid, req_type, tgt_id, role, query_kind, healthy, lag_ms,
                output ready);
endinterface

interface rwbs_res_if;
  logic                      valid;
  logic                      ready;
  logic [rwbs_pkg::ST_W-1:0] status;
  logic [rwbs_pkg::ID_W-1:0] selected_id;

  modport source (output valid, status, selected_id, input ready);
  modport sink (input valid, status, selected_id, output ready);
endinterface

interface rwbs_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rwbs_pkg::LAG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- design/rwbs_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rwbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/read_write_backend_selector.sv -----
// Add, table full, unknown id and no-candidate requests go from the idle state to S_DONE;
// update, acquire, release and session selects pass S_RMW first (table read, then a write for
// all but the session select). A select without session scans the table once, newest entry
// first, one entry per cycle through the table RAM port and one comparator, then S_PICK. The
// next request can transfer once S_DONE has loaded the result register, which waits while the
// last result is stalled. Reset (synchronous, rst_n low) empties the table, sets the lag limit
// to 5000 and drops any pending result; entries hold no value until their backend is added.
`timescale 1ns / 1ps
`default_nettype none

module read_write_backend_selector #(
  parameter int MAX_BACKENDS = rwbs_pkg::MAX_BACKENDS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  rwbs_req_if.sink   in_chan,
  rwbs_res_if.source out_chan,
  rwbs_cfg_if.sink   cfg_chan
);

  localparam int CW  = $clog2(MAX_BACKENDS + 1);
  localparam int AW  = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int AW1 = AW + 1;
  localparam int KW  = (CW > rwbs_pkg::ID_W) ? CW : rwbs_pkg::ID_W;
  localparam int EW  = $bits(rwbs_pkg::entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RMW  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [rwbs_pkg::LAG_W-1:0]     lag_limit_r, lag_limit_nxt;
  logic [rwbs_pkg::REQ_W-1:0]     req_type_r, req_type_nxt;
  logic [rwbs_pkg::ID_W-1:0]      req_id_r, req_id_nxt;
  logic                           req_hl_r, req_hl_nxt;
  logic [rwbs_pkg::LAG_W-1:0]     req_lag_r, req_lag_nxt;
  logic                           is_read_r, is_read_nxt;
  logic [AW-1:0]                  tgt_idx_r, tgt_idx_nxt;
  logic [AW-1:0]                  scan_idx_r, scan_idx_nxt;
  logic                           pri_found_r, pri_found_nxt;
  logic [AW-1:0]                  pri_idx_r, pri_idx_nxt;
  logic                           rep_found_r, rep_found_nxt;
  logic [AW-1:0]                  rep_idx_r, rep_idx_nxt;
  logic [rwbs_pkg::ACT_W-1:0]     rep_act_r, rep_act_nxt;
  logic [rwbs_pkg::LAG_W-1:0]     rep_lag_r, rep_lag_nxt;
  logic [rwbs_pkg::ST_W-1:0]      res_status_r, res_status_nxt;
  logic [rwbs_pkg::ID_W-1:0]      res_id_r, res_id_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [rwbs_pkg::ST_W-1:0]      out_status_r, out_status_nxt;
  logic [rwbs_pkg::ID_W-1:0]      out_id_r, out_id_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr, ram_raddr;
  rwbs_pkg::entry_t               wr_e, rd_e;
  logic [EW-1:0]                  ram_rdata;

  logic                           accept;
  logic [KW-1:0]                  id_ext, cnt_ext;
  logic                           id_known, full;
  logic [AW-1:0]                  id_idx, last_idx;
  logic                           pri_hit, rep_ok, rep_better;

  rwbs_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_BACKENDS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_e),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e = rwbs_pkg::entry_t'(ram_rdata);

  assign in_chan.ready        = (state_r == S_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.selected_id = out_id_r;

  assign accept   = in_chan.valid && (state_r == S_IDLE);
  assign id_ext   = KW'(in_chan.tgt_id);
  assign cnt_ext  = KW'(count_r);
  assign id_known = (id_ext != '0) && (id_ext <= cnt_ext);
  assign id_idx   = AW'(id_ext - KW'(1));
  assign last_idx = AW'(cnt_ext - KW'(1));
  assign full     = (count_r >= CW'(MAX_BACKENDS));

  // Scan comparator: newest healthy primary, and the healthy replica under the lag limit with
  // fewest connections, then lag; entries come newest first, so ties on both keep the held one.
  assign pri_hit    = (rd_e.role == rwbs_pkg::ROLE_PRIMARY) && rd_e.healthy;
  assign rep_ok     = (rd_e.role == rwbs_pkg::ROLE_REPLICA) && rd_e.healthy &&
                      (rd_e.lag < lag_limit_r);
  assign rep_better = !rep_found_r || (rd_e.active < rep_act_r) ||
                      ((rd_e.active == rep_act_r) && (rd_e.lag < rep_lag_r));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lag_limit_nxt  = lag_limit_r;
    req_type_nxt   = req_type_r;
    req_id_nxt     = req_id_r;
    req_hl_nxt     = req_hl_r;
    req_lag_nxt    = req_lag_r;
    is_read_nxt    = is_read_r;
    tgt_idx_nxt    = tgt_idx_r;
    scan_idx_nxt   = scan_idx_r;
    pri_found_nxt  = pri_found_r;
    pri_idx_nxt    = pri_idx_r;
    rep_found_nxt  = rep_found_r;
    rep_idx_nxt    = rep_idx_r;
    rep_act_nxt    = rep_act_r;
    rep_lag_nxt    = rep_lag_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    ram_we         = 1'b0;
    ram_waddr      = tgt_idx_r;
    ram_raddr      = id_idx;
    wr_e           = rd_e;

    if (cfg_chan.valid) begin
      lag_limit_nxt = cfg_chan.data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_type_nxt   = in_chan.req_type;
          req_id_nxt     = in_chan.tgt_id;
          req_hl_nxt     = in_chan.healthy;
          req_lag_nxt    = in_chan.lag_ms;
          is_read_nxt    = (in_chan.query_kind == rwbs_pkg::KIND_READ);
          tgt_idx_nxt    = id_idx;
          res_status_nxt = rwbs_pkg::ST_NONE;
          res_id_nxt     = '0;
          state_nxt      = S_DONE;
          unique case (in_chan.req_type) inside
            rwbs_pkg::REQ_ADD: begin
              if (full) begin
                res_status_nxt = rwbs_pkg::ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = AW'(count_r);
                wr_e.role      = in_chan.role;
                wr_e.healthy   = 1'b1;
                wr_e.lag       = '0;
                wr_e.active    = '0;
                count_nxt      = count_r + CW'(1);
                res_status_nxt = rwbs_pkg::ST_OK;
                res_id_nxt     = rwbs_pkg::ID_W'(cnt_ext + KW'(1));
              end
            end
            rwbs_pkg::REQ_SELECT: begin
              if (in_chan.tgt_id != '0) begin
                if (id_known) begin
                  state_nxt = S_RMW;
                end else begin
                  res_status_nxt = rwbs_pkg::ST_UNKNOWN;
                end
              end else if ((in_chan.query_kind inside {rwbs_pkg::KIND_READ,
                                                       rwbs_pkg::KIND_WRITE,
                                                       rwbs_pkg::KIND_TXN,
                                                       rwbs_pkg::KIND_SESS}) &&
                           (count_r != '0)) begin
                ram_raddr     = last_idx;
                scan_idx_nxt  = last_idx;
                pri_found_nxt = 1'b0;
                rep_found_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            rwbs_pkg::REQ_UPDATE, rwbs_pkg::REQ_ACQUIRE, rwbs_pkg::REQ_RELEASE: begin
              if (id_known) begin
                state_nxt = S_RMW;
              end else begin
                res_status_nxt = rwbs_pkg::ST_UNKNOWN;
              end
            end
            default: begin
              res_status_nxt = rwbs_pkg::ST_NONE;
            end
          endcase
        end
      end

      S_RMW: begin
        res_status_nxt = rwbs_pkg::ST_OK;
        res_id_nxt     = req_id_r;
        state_nxt      = S_DONE;
        case (req_type_r)
          rwbs_pkg::REQ_UPDATE: begin
            ram_we       = 1'b1;
            wr_e.healthy = req_hl_r;
            wr_e.lag     = req_lag_r;
          end
          rwbs_pkg::REQ_ACQUIRE: begin
            ram_we = 1'b1;
            if (rd_e.active != rwbs_pkg::ACT_MAX) begin
              wr_e.active = rd_e.active + rwbs_pkg::ACT_W'(1);
            end
          end
          rwbs_pkg::REQ_RELEASE: begin
            ram_we = 1'b1;
            if (rd_e.active != '0) begin
              wr_e.active = rd_e.active - rwbs_pkg::ACT_W'(1);
            end
          end
          default: begin
            // Session select: the named backend only if it is healthy.
            if (!rd_e.healthy) begin
              res_status_nxt = rwbs_pkg::ST_NONE;
              res_id_nxt     = '0;
            end
          end
        endcase
      end

      S_SCAN: begin
        // Read data belongs to scan_idx_r; the next lower entry is addressed meanwhile.
        ram_raddr = scan_idx_r - AW'(1);
        if (!pri_found_r && pri_hit) begin
          pri_found_nxt = 1'b1;
          pri_idx_nxt   = scan_idx_r;
        end
        if (rep_ok && rep_better) begin
          rep_found_nxt = 1'b1;
          rep_idx_nxt   = scan_idx_r;
          rep_act_nxt   = rd_e.active;
          rep_lag_nxt   = rd_e.lag;
        end
        scan_idx_nxt = scan_idx_r - AW'(1);
        if (scan_idx_r == '0) begin
          state_nxt = S_PICK;
        end
      end

      S_PICK: begin
        state_nxt = S_DONE;
        if (is_read_r && rep_found_r) begin
          res_status_nxt = rwbs_pkg::ST_OK;
          res_id_nxt     = rwbs_pkg::ID_W'({1'b0, rep_idx_r} + AW1'(1));
        end else if (pri_found_r) begin
          res_status_nxt = rwbs_pkg::ST_OK;
          res_id_nxt     = rwbs_pkg::ID_W'({1'b0, pri_idx_r} + AW1'(1));
        end else begin
          res_status_nxt = rwbs_pkg::ST_NONE;
          res_id_nxt     = '0;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      lag_limit_r <= rwbs_pkg::LAG_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lag_limit_r <= lag_limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    req_id_r     <= req_id_nxt;
    req_hl_r     <= req_hl_nxt;
    req_lag_r    <= req_lag_nxt;
    is_read_r    <= is_read_nxt;
    tgt_idx_r    <= tgt_idx_nxt;
    scan_idx_r   <= scan_idx_nxt;
    pri_found_r  <= pri_found_nxt;
    pri_idx_r    <= pri_idx_nxt;
    rep_found_r  <= rep_found_nxt;
    rep_idx_r    <= rep_idx_nxt;
    rep_act_r    <= rep_act_nxt;
    rep_lag_r    <= rep_lag_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

endmodule

`default_nettype wire

// ----- design/rwbs_checker.sv -----
// Port-level checker for the backend selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rwbs_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [rwbs_pkg::ST_W-1:0] out_status,
  input logic [rwbs_pkg::ID_W-1:0] out_selected_id
);

  logic res_failed;
  logic out_stall;

  assign res_failed = out_valid && (out_status != rwbs_pkg::ST_OK);
  assign out_stall  = out_valid && !out_ready;

  // The block works on one request at a time: a transfer closes the input side.
  `CHK_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "input ready after transfer")

  // Any failing status carries no backend id.
  `CHK_SAME(a_fail_no_id, res_failed, out_selected_id == '0, "id on failed result")

  `CHK_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")

  `CHK_NEXT(a_out_stable, out_stall, $stable({out_status, out_selected_id}), "result changed")

endmodule

bind read_write_backend_selector rwbs_checker u_rwbs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_selected_id (out_chan.selected_id)
);

`default_nettype wire

// ----- tb/selector_checker.sv -----
// Checker for the backend selector: tracks the backend table, predicts every result and compares.
`timescale 1ns / 1ps
`default_nettype none

module selector_checker #(
  parameter int MAX_BACKENDS = rwbs_pkg::MAX_BACKENDS_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  rwbs_req_if  req_mon,
  rwbs_res_if  res_mon,
  rwbs_cfg_if  cfg_mon,
  output int   errors,
  output int   pending,
  output int   checked
);
  import rwbs_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] id;
  } pick_t;

  entry_t           backends [MAX_BACKENDS];
  int unsigned      n_backends;
  logic [LAG_W-1:0] lag_limit;
  pick_t            expected_picks [$];

  task automatic report_mismatch(string msg);
    if (errors < 40) $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [ID_W-1:0] newest_primary();
    for (int i = n_backends; i >= 1; i--)
      if (backends[i-1].role == ROLE_PRIMARY && backends[i-1].healthy) return ID_W'(i);
    return '0;
  endfunction

  // Scan from the newest entry down; only a strictly better candidate replaces the
  // current one, so full ties stay with the newer backend.
  function automatic logic [ID_W-1:0] least_loaded_replica();
    logic [ID_W-1:0]  best;
    logic [ACT_W-1:0] best_act;
    logic [LAG_W-1:0] best_lag;
    best = '0;
    best_act = '0;
    best_lag = '0;
    for (int i = n_backends; i >= 1; i--) begin
      if (backends[i-1].role == ROLE_REPLICA && backends[i-1].healthy &&
          backends[i-1].lag < lag_limit) begin
        if (best == 0 || backends[i-1].active < best_act ||
            (backends[i-1].active == best_act && backends[i-1].lag < best_lag)) begin
          best = ID_W'(i);
          best_act = backends[i-1].active;
          best_lag = backends[i-1].lag;
        end
      end
    end
    return best;
  endfunction

  function automatic pick_t serve_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                          logic role, logic [KIND_W-1:0] kind,
                                          logic hl, logic [LAG_W-1:0] lag);
    pick_t p;
    logic  known;
    int    k;
    p.status = ST_NONE;
    p.id = '0;
    known = (id >= 1) && (id <= n_backends);
    k = int'(id) - 1;
    case (req) inside
      REQ_ADD: begin
        if (n_backends >= MAX_BACKENDS) begin
          p.status = ST_FULL;
        end else begin
          backends[n_backends] = '{role: role, healthy: 1'b1, lag: '0, active: '0};
          n_backends++;
          p.status = ST_OK;
          p.id = ID_W'(n_backends);
        end
      end
      REQ_SELECT: begin
        if (id != 0) begin
          if (!known) p.status = ST_UNKNOWN;
          else if (backends[k].healthy) begin
            p.status = ST_OK;
            p.id = id;
          end
        end else begin
          if (kind == KIND_WRITE || kind == KIND_TXN || kind == KIND_SESS) begin
            p.id = newest_primary();
          end else if (kind == KIND_READ) begin
            p.id = least_loaded_replica();
            if (p.id == 0) p.id = newest_primary();
          end
          if (p.id != 0) p.status = ST_OK;
        end
      end
      REQ_UPDATE, REQ_ACQUIRE, REQ_RELEASE: begin
        if (!known) begin
          p.status = ST_UNKNOWN;
        end else begin
          if (req == REQ_UPDATE) begin
            backends[k].healthy = hl;
            backends[k].lag = lag;
          end else if (req == REQ_ACQUIRE) begin
            if (backends[k].active != ACT_MAX) backends[k].active = backends[k].active + 1'b1;
          end else begin
            if (backends[k].active != 0) backends[k].active = backends[k].active - 1'b1;
          end
          p.status = ST_OK;
          p.id = id;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  always @(posedge clk) begin
    pick_t want;
    if (!rst_n) begin
      n_backends = 0;
      lag_limit = LAG_LIMIT_RESET;
      expected_picks.delete();
      errors = 0;
      checked = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) lag_limit = cfg_mon.data;
      if (res_mon.valid && res_mon.ready) begin
        if (expected_picks.size() == 0) begin
          report_mismatch($sformatf("result status %0d id %0d with no request outstanding",
                                    res_mon.status, res_mon.selected_id));
        end else begin
          want = expected_picks.pop_front();
          checked++;
          if (res_mon.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, res_mon.status));
          if (res_mon.selected_id !== want.id)
            report_mismatch($sformatf("selected_id expected %0d got %0d",
                                      want.id, res_mon.selected_id));
        end
      end
      if (req_mon.valid && req_mon.ready)
        expected_picks.push_back(serve_request(req_mon.req_type, req_mon.tgt_id,
                                               req_mon.role, req_mon.query_kind,
                                               req_mon.healthy, req_mon.lag_ms));
    end
    pending = expected_picks.size();
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Testbench top: drives requests, result back-pressure and lag limit writes, and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import rwbs_pkg::*;

  localparam int NBACK          = MAX_BACKENDS_DEFAULT;
  localparam int RANDOM_ITEMS   = 1048;
  localparam int PHASES         = 4;
  localparam int STALL_LIMIT    = 3000;
  localparam int BURST_ACQUIRES = 24;

  // Request types and query kinds outside the defined set.
  localparam logic [REQ_W-1:0]  REQ_RSVD_FIRST = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_RSVD_LAST  = 3'd7;
  localparam logic [KIND_W-1:0] KIND_OTHER     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_RSVD      = 3'd7;

  logic clk;
  logic rst_n;
  int   errors, pending, checked;
  int   stall_cycles = 0;
  int   out_hold = 0;
  int   in_idle_pct, out_idle_pct;
  int   n_added, n_sent, n_reads;
  logic [LAG_W-1:0] cur_limit;

  rwbs_req_if req_ch ();
  rwbs_res_if res_ch ();
  rwbs_cfg_if cfg_ch ();

  read_write_backend_selector #(.MAX_BACKENDS(NBACK)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_ch),
    .out_chan (res_ch),
    .cfg_chan (cfg_ch)
  );

  selector_checker #(.MAX_BACKENDS(NBACK)) u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_mon (req_ch),
    .res_mon (res_ch),
    .cfg_mon (cfg_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int pause_len();
    return ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
  endfunction

  always @(negedge clk) begin
    if (out_hold > 0) begin
      res_ch.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else if ($urandom_range(99) < out_idle_pct) begin
      res_ch.ready <= 1'b0;
      out_hold <= pause_len() - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_req(logic [REQ_W-1:0] req, logic [ID_W-1:0] id, logic role,
                          logic [KIND_W-1:0] kind, logic hl, logic [LAG_W-1:0] lag);
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= req;
    req_ch.tgt_id     <= id;
    req_ch.role       <= role;
    req_ch.query_kind <= kind;
    req_ch.healthy    <= hl;
    req_ch.lag_ms     <= lag;
    do @(posedge clk); while (!req_ch.ready);
    n_sent++;
    if (req == REQ_ADD && n_added < NBACK) n_added++;
    if (req == REQ_SELECT && id == 0 && kind == KIND_READ) n_reads++;
    if ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (pause_len()) @(negedge clk);
    end
  endtask

  // Leaves the request channel quiet until every outstanding result has come back.
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Called right after drain, at a falling edge with the block idle.
  task automatic write_lag_limit(logic [LAG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_limit = value;
  endtask

  function automatic logic [ID_W-1:0] target_id();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 8) return ID_W'($urandom_range(31, 17));
    if (r < 12) return ID_W'(n_added + 1);
    return ID_W'($urandom_range((n_added > 0) ? n_added : 1, 1));
  endfunction

  // Lags cluster around the current limit so replicas move in and out of the read pool.
  function automatic logic [LAG_W-1:0] pick_lag();
    case ($urandom_range(7))
      0: return '0;
      1: return cur_limit - 1'b1;
      2: return cur_limit;
      3: return cur_limit + 1'b1;
      4: return $urandom;
      5: return '1;
      default: return $urandom_range(10000);
    endcase
  endfunction

  function automatic logic [REQ_W-1:0] req_type_bad();
    return REQ_W'($urandom_range(REQ_RSVD_LAST, REQ_RSVD_FIRST));
  endfunction

  task automatic random_request();
    int r;
    int q;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(99);
    if (r < 4) begin
      send_req(REQ_ADD, ID_W'($urandom), 1'($urandom), KIND_W'($urandom), 1'($urandom),
               LAG_W'($urandom));
    end else if (r < 49) begin
      q = $urandom_range(99);
      if (q < 55) kind = KIND_READ;
      else if (q < 70) kind = KIND_WRITE;
      else if (q < 80) kind = KIND_TXN;
      else if (q < 90) kind = KIND_SESS;
      else kind = KIND_W'($urandom_range(KIND_RSVD, KIND_OTHER));
      if ($urandom_range(3) != 0)
        send_req(REQ_SELECT, '0, 1'($urandom), kind, 1'($urandom), LAG_W'($urandom));
      else
        send_req(REQ_SELECT, target_id(), 1'($urandom), kind, 1'($urandom),
                 LAG_W'($urandom));
    end else if (r < 67) begin
      send_req(REQ_ACQUIRE, target_id(), 1'($urandom), KIND_W'($urandom), 1'($urandom),
               LAG_W'($urandom));
    end else if (r < 81) begin
      send_req(REQ_RELEASE, target_id(), 1'($urandom), KIND_W'($urandom), 1'($urandom),
               LAG_W'($urandom));
    end else if (r < 97) begin
      send_req(REQ_UPDATE, target_id(), 1'($urandom), KIND_W'($urandom),
               $urandom_range(4) != 0, pick_lag());
    end else begin
      send_req(req_type_bad(), target_id(), 1'($urandom), KIND_W'($urandom), 1'($urandom),
               LAG_W'($urandom));
    end
  endtask

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_ADD;
    req_ch.tgt_id     = '0;
    req_ch.role       = ROLE_PRIMARY;
    req_ch.query_kind = KIND_READ;
    req_ch.healthy    = 1'b0;
    req_ch.lag_ms     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    cur_limit         = LAG_LIMIT_RESET;
    in_idle_pct       = 30;
    out_idle_pct      = 30;
    n_added           = 0;
    n_sent            = 0;
    n_reads           = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: every select and every targeted request has nowhere to go.
    send_req(REQ_SELECT, '0, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_SELECT, '0, 1'b1, KIND_WRITE, 1'b1, '1);
    send_req(REQ_UPDATE, 5'd1, 1'b0, KIND_READ, 1'b1, '1);
    send_req(REQ_ACQUIRE, '0, 1'b0, KIND_READ, 1'b0, '0);
    // One replica, then a primary; ignored fields carry their extremes.
    send_req(REQ_ADD, 5'd31, ROLE_REPLICA, KIND_RSVD, 1'b0, '1);
    send_req(REQ_SELECT, '0, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_SELECT, '0, 1'b0, KIND_SESS, 1'b0, '0);
    send_req(REQ_ADD, '0, ROLE_PRIMARY, KIND_READ, 1'b1, '0);
    send_req(REQ_SELECT, '0, 1'b0, KIND_WRITE, 1'b0, '0);
    send_req(REQ_SELECT, '0, 1'b0, KIND_TXN, 1'b0, '0);
    send_req(REQ_SELECT, '0, 1'b0, KIND_OTHER, 1'b0, '0);
    send_req(REQ_SELECT, '0, 1'b0, KIND_RSVD, 1'b0, '0);
    // Replica lag at the 32-bit maximum: reads fall back to the primary.
    send_req(REQ_UPDATE, 5'd1, 1'b0, KIND_READ, 1'b1, '1);
    send_req(REQ_SELECT, '0, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_UPDATE, 5'd2, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_SELECT, '0, 1'b0, KIND_READ, 1'b0, '0);
    // Session selects: unhealthy, healthy, and ids beyond the table.
    send_req(REQ_SELECT, 5'd2, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_SELECT, 5'd1, 1'b0, KIND_WRITE, 1'b0, '0);
    send_req(REQ_SELECT, 5'd31, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_SELECT, 5'd3, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_RELEASE, 5'd1, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_RSVD_FIRST, 5'd1, 1'b1, KIND_READ, 1'b1, '0);
    send_req(REQ_RSVD_LAST, 5'd2, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_UPDATE, 5'd16, 1'b0, KIND_READ, 1'b1, '0);
    send_req(REQ_UPDATE, 5'd1, 1'b0, KIND_READ, 1'b1, '0);
    send_req(REQ_UPDATE, 5'd2, 1'b0, KIND_READ, 1'b1, '0);

    // Back-to-back acquires raise the replica's count; a release and more acquires follow.
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (BURST_ACQUIRES) send_req(REQ_ACQUIRE, 5'd1, 1'b0, KIND_READ, 1'b0, '0);
    send_req(REQ_RELEASE, 5'd1, 1'b0, KIND_READ, 1'b0, '0);
    repeat (2) send_req(REQ_ACQUIRE, 5'd1, 1'b0, KIND_READ, 1'b0, '0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 1) write_lag_limit('0);
      else if (ph == 2) write_lag_limit('1);
      else if (ph == 3) write_lag_limit(LAG_W'($urandom_range(20000, 1)));
      for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
        if (i % 50 == 0) begin
          case ($urandom_range(2))
            0: in_idle_pct = 0;
            1: in_idle_pct = 25;
            default: in_idle_pct = 60;
          endcase
          case ($urandom_range(2))
            0: out_idle_pct = 0;
            1: out_idle_pct = 25;
            default: out_idle_pct = 60;
          endcase
        end
        random_request();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Ran %0d requests (%0d read selects without session) over %0d backends,",
             n_sent, n_reads, n_added);
    $display("with acquire bursts and lag limits 5000, 0, max and %0d; %0d results checked.",
             cur_limit, checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/rwbs_pkg.sv
design/rwbs_ifs.sv
design/rwbs_ram.sv
design/read_write_backend_selector.sv
design/rwbs_checker.sv
tb/selector_checker.sv
tb/tb.sv
